// ===== src/wdsf_pkg.sv =====
package wdsf_pkg;

   localparam int SAMPLE_WIDTH = 24;
   localparam int COEF_WIDTH = 24;
   localparam int WAVE_WIDTH = 32;
   localparam int COEF_FRAC = COEF_WIDTH - 4;
   localparam int PORTS = 5;
   localparam int WAVES = 4;
   localparam int INDEX_WIDTH = 3;

   // exact product, and a sum of PORTS products
   localparam int PROD_WIDTH = WAVE_WIDTH + COEF_WIDTH;
   localparam int ACC_WIDTH = PROD_WIDTH + $clog2(PORTS);

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_COEF = 1'b1;

   typedef logic signed [WAVE_WIDTH-1:0] wave_type;
   typedef logic signed [COEF_WIDTH-1:0] coef_type;
   typedef logic signed [PROD_WIDTH-1:0] prod_type;
   typedef logic signed [ACC_WIDTH-1:0] acc_type;

   typedef wave_type vec_type [PORTS];
   typedef coef_type row_type [PORTS];

   typedef struct packed {
      logic                           cmd;
      logic signed [SAMPLE_WIDTH-1:0] sample_in;
      logic [INDEX_WIDTH-1:0]         coef_row;
      logic [INDEX_WIDTH-1:0]         coef_col;
      logic signed [COEF_WIDTH-1:0]   coef_value;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample_out;
      logic                           clipped;
   } rsp_type;

endpackage

// ===== src/wave_digital_scattering_filter_top.sv =====
// Wave digital scattering step. Each audio item (cmd = 0) is scaled by a 5x5 coefficient
// matrix together with the four stored waves; the four new waves are kept and half the
// output wave comes back as one result item, rounded half up and saturated, with clipped
// set if the output or any wave saturated. A coefficient item (cmd = 1) writes one matrix
// word and gives no result; words with row or column above 4 are dropped. Items are taken
// one per clock unless an audio item waits on a full result register that is not taken:
// each sits in the input register while the five dot products run in parallel, and the
// result register follows. The loop from the wave registers through the dot products
// sets that rate. Waves and coefficients are zero after reset.
module wave_digital_scattering_filter_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  wdsf_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output wdsf_pkg::rsp_type rsp_item
);
   import wdsf_pkg::*;

   localparam int SAMPLE_PORT = 3;
   localparam int OUT_ROW = 4;

   typedef logic signed [ACC_WIDTH:0] round_type;

   localparam round_type WAVE_HI = (round_type'(1) <<< (WAVE_WIDTH - 1)) - round_type'(1);
   localparam round_type WAVE_LO = -WAVE_HI - round_type'(1);
   localparam round_type OUT_HI = (round_type'(1) <<< (SAMPLE_WIDTH - 1)) - round_type'(1);
   localparam round_type OUT_LO = -OUT_HI - round_type'(1);

   function automatic round_type round_shift(acc_type a, int s);
      round_type t;
      t = round_type'(a) + (round_type'(1) <<< (s - 1));
      return t >>> s;
   endfunction

   logic     item_valid_ff, item_valid_in;
   req_type  item_ff, item_in;
   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_item_ff, rsp_item_in;
   wave_type wave_ff [WAVES];
   wave_type wave_in [WAVES];
   coef_type coef_ff [PORTS][PORTS];
   coef_type coef_in [PORTS][PORTS];

   vec_type   vec;
   acc_type   acc [PORTS];
   round_type rnd_wave [WAVES];
   round_type rnd_out;
   wave_type  next_wave [WAVES];
   logic      clip;
   logic signed [SAMPLE_WIDTH-1:0] y;

   logic is_sample, out_free, fire;

   assign is_sample = (item_ff.cmd == CMD_SAMPLE);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign fire = item_valid_ff && (!is_sample || out_free);
   // nothing is taken while reset is held
   assign req_ready = !reset && (!item_valid_ff || fire);

   // incident vector: waves 0..2, sample, wave 3
   always_comb begin
      vec[0] = wave_ff[0];
      vec[1] = wave_ff[1];
      vec[2] = wave_ff[2];
      vec[SAMPLE_PORT] = wave_type'(item_ff.sample_in);
      vec[OUT_ROW] = wave_ff[3];
   end

   for (genvar r = 0; r < PORTS; r++) begin : g_row
      wdsf_dot u_dot (
         .vec_in  (vec),
         .coef_in (coef_ff[r]),
         .acc_out (acc[r])
      );
   end

   always_comb begin
      clip = 1'b0;
      for (int r = 0; r < WAVES; r++) begin
         rnd_wave[r] = round_shift(acc[r], COEF_FRAC);
         if (rnd_wave[r] > WAVE_HI) begin
            next_wave[r] = WAVE_WIDTH'(WAVE_HI);
            clip = 1'b1;
         end else if (rnd_wave[r] < WAVE_LO) begin
            next_wave[r] = WAVE_WIDTH'(WAVE_LO);
            clip = 1'b1;
         end else begin
            next_wave[r] = WAVE_WIDTH'(rnd_wave[r]);
         end
      end
      // extra shift bit does the halving
      rnd_out = round_shift(acc[OUT_ROW], COEF_FRAC + 1);
      if (rnd_out > OUT_HI) begin
         y = SAMPLE_WIDTH'(OUT_HI);
         clip = 1'b1;
      end else if (rnd_out < OUT_LO) begin
         y = SAMPLE_WIDTH'(OUT_LO);
         clip = 1'b1;
      end else begin
         y = SAMPLE_WIDTH'(rnd_out);
      end
   end

   always_comb begin
      item_valid_in = item_valid_ff;
      item_in = item_ff;
      if (req_ready) begin
         item_valid_in = req_valid;
         item_in = req_item;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_item_in = rsp_item_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (fire && is_sample) begin
         rsp_valid_in = 1'b1;
         rsp_item_in.sample_out = y;
         rsp_item_in.clipped = clip;
      end

      wave_in = wave_ff;
      if (fire && is_sample) begin
         wave_in = next_wave;
      end

      coef_in = coef_ff;
      for (int r = 0; r < PORTS; r++) begin
         for (int c = 0; c < PORTS; c++) begin
            if (fire && !is_sample && item_ff.coef_row == INDEX_WIDTH'(r)
                  && item_ff.coef_col == INDEX_WIDTH'(c)) begin
               coef_in[r][c] = item_ff.coef_value;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int r = 0; r < WAVES; r++) begin
            wave_ff[r] <= '0;
         end
         for (int r = 0; r < PORTS; r++) begin
            for (int c = 0; c < PORTS; c++) begin
               coef_ff[r][c] <= '0;
            end
         end
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         wave_ff <= wave_in;
         coef_ff <= coef_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_item_ff;

endmodule

// ===== src/wdsf_dot.sv =====
module wdsf_dot (
   input  wdsf_pkg::vec_type vec_in,
   input  wdsf_pkg::row_type coef_in,
   output wdsf_pkg::acc_type acc_out
);
   import wdsf_pkg::*;

   prod_type prod [PORTS];

   // all products side by side, then one chain of adds
   always_comb begin
      for (int c = 0; c < PORTS; c++) begin
         prod[c] = prod_type'(vec_in[c]) * prod_type'(coef_in[c]);
      end
   end

   always_comb begin
      acc_out = '0;
      for (int c = 0; c < PORTS; c++) begin
         acc_out = acc_out + acc_type'(prod[c]);
      end
   end

endmodule

// ===== src/wdsf_checker.sv =====
module wdsf_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input wdsf_pkg::req_type req_item,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input wdsf_pkg::rsp_type rsp_item
);
   import wdsf_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("result changed while stalled");

   // a fresh result comes from an audio item that passed the input register
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_item.cmd == CMD_SAMPLE, 2))
      else $error("result without a matching audio item");

   // with the result side empty the input side never stalls
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind wave_digital_scattering_filter_top wdsf_checker u_wdsf_checker (.*);
